>>> rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg : shared types and constants of the ring message queue
// Request and result codes, default sizes and the register map.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned DepthDef    = 16;
  localparam int unsigned MsgWidthDef = 32;

  // Register map: one word per register, index taken from paddr[2]
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;
  localparam logic        RegQueueCap = 1'b0;

  // Request kinds
  typedef enum logic [1:0] {
    ACT_POST_BACK  = 2'd0,
    ACT_POST_FRONT = 2'd1,
    ACT_RECEIVE    = 2'd2,
    ACT_FLUSH      = 2'd3
  } action_e;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-request control handed from the queue control to the result stage
  typedef struct packed {
    status_e status;
    logic    take;    // successful receive: message comes from the store
  } res_ctl_t;

endpackage

>>> rtl/rmq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_if : request and result channels of the ring message queue
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
interface rmq_req_if #(
  parameter int unsigned MsgW = rmq_pkg::MsgWidthDef
);
  logic              valid;
  logic              ready;
  rmq_pkg::action_e  action;
  logic [MsgW-1:0]   message_in;

  modport source (output valid, output action, output message_in, input ready);
  modport sink   (input valid, input action, input message_in, output ready);
endinterface

interface rmq_res_if #(
  parameter int unsigned MsgW = rmq_pkg::MsgWidthDef,
  parameter int unsigned CntW = $clog2(rmq_pkg::DepthDef + 1)
);
  logic              valid;
  logic              ready;
  rmq_pkg::status_e  status;
  logic [MsgW-1:0]   message_out;
  logic [CntW-1:0]   entry_count;

  modport source (output valid, output status, output message_out,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input message_out,
                  input entry_count, output ready);
endinterface

>>> rtl/rmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_ram : generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmq_ram #(
  parameter int unsigned Width = rmq_pkg::MsgWidthDef,
  parameter int unsigned Depth = rmq_pkg::DepthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rmq_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_cfg : configuration register block
// APB-style port holding the queue capacity register.
// ----------------------------------------------------------------------------
module rmq_cfg #(
  parameter int unsigned Depth = rmq_pkg::DepthDef,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmq_pkg::PaddrW-1:0] paddr,
  input  logic [rmq_pkg::PdataW-1:0] pwdata,
  output logic [rmq_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  output logic [CntW-1:0]            cap_o
);

  logic [CntW-1:0] cap_q;
  logic            sel_cap;

  // word index lives in paddr[2]
  assign sel_cap = (paddr[2] == rmq_pkg::RegQueueCap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CntW'(Depth);
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_q <= pwdata[CntW-1:0];
    end
  end

  // read back
  assign prdata = sel_cap ? rmq_pkg::PdataW'(cap_q) : '0;
  assign pready = 1'b1;
  assign cap_o  = cap_q;

endmodule

>>> rtl/rmq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_ctrl : queue pointer and count control
// Head, tail and count registers; drives the ring store ports per request.
// ----------------------------------------------------------------------------
module rmq_ctrl #(
  parameter int unsigned Depth = rmq_pkg::DepthDef,
  localparam int unsigned AddrW = $clog2(Depth),
  localparam int unsigned CntW  = $clog2(Depth + 1),
  localparam int unsigned ExtW  = CntW + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rmq_pkg::action_e  action_i,
  input  logic [CntW-1:0]   cap_i,
  output logic              ram_we_o,
  output logic [AddrW-1:0]  ram_waddr_o,
  output logic              ram_re_o,
  output logic [AddrW-1:0]  ram_raddr_o,
  output rmq_pkg::res_ctl_t ctl_o,
  output logic [CntW-1:0]   count_o
);

  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  cap_eff;
  logic             full;
  logic             empty;
  logic [AddrW-1:0] head_next;
  logic [AddrW-1:0] tail_next;
  logic [AddrW-1:0] head_prev;

  // step a pointer forward, wrapping at the capacity
  function automatic logic [AddrW-1:0] advance(input logic [AddrW-1:0] idx,
                                               input logic [CntW-1:0]  cap);
    logic [ExtW-1:0] nxt;
    nxt = ExtW'(idx) + ExtW'(1);
    return (nxt >= ExtW'(cap)) ? '0 : nxt[AddrW-1:0];
  endfunction

  // capacity clamped to 1..Depth
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_i > CntW'(Depth)) begin
      cap_eff = CntW'(Depth);
    end else begin
      cap_eff = cap_i;
    end
  end

  assign full      = (count_q >= cap_eff);
  assign empty     = (count_q == '0);
  assign head_next = advance(head_q, cap_eff);
  assign tail_next = advance(tail_q, cap_eff);

  // head stepped back; from entry 0 or beyond capacity it goes to the top
  always_comb begin
    if (head_q == '0 || ExtW'(head_q) >= ExtW'(cap_eff)) begin
      head_prev = AddrW'(cap_eff - CntW'(1));
    end else begin
      head_prev = head_q - AddrW'(1);
    end
  end

  // next state and store access per request
  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = tail_q;
    ram_re_o     = 1'b0;
    ctl_o.status = rmq_pkg::ST_OK;
    ctl_o.take   = 1'b0;
    case (action_i)
      rmq_pkg::ACT_POST_BACK: begin
        if (full) begin
          ctl_o.status = rmq_pkg::ST_FULL;
        end else begin
          ram_we_o = fire_i;
          tail_d   = tail_next;
          count_d  = count_q + CntW'(1);
        end
      end
      rmq_pkg::ACT_POST_FRONT: begin
        ram_waddr_o = head_prev;
        if (full) begin
          ctl_o.status = rmq_pkg::ST_FULL;
        end else begin
          ram_we_o = fire_i;
          head_d   = head_prev;
          count_d  = count_q + CntW'(1);
        end
      end
      rmq_pkg::ACT_RECEIVE: begin
        if (empty) begin
          ctl_o.status = rmq_pkg::ST_EMPTY;
        end else begin
          ram_re_o   = fire_i;
          ctl_o.take = 1'b1;
          head_d     = head_next;
          count_d    = count_q - CntW'(1);
        end
      end
      default: begin
        head_d  = '0;
        tail_d  = '0;
        count_d = '0;
      end
    endcase
  end

  assign ram_raddr_o = head_q;
  assign count_o     = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

endmodule

>>> rtl/ring_message_queue_with_front_post_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_message_queue_with_front_post_core : ring message queue, top level
// Circular queue with post at tail, post at front, receive and flush.
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    action, message_in
//   res_o    out  valid / ready    status, message_out, entry_count
//   apb      in   psel / penable   paddr, pwdata, prdata (queue_capacity)
//
// One request per cycle; each result appears the cycle after its request.
// The single result register is refilled in the cycle it is taken, so a
// stall on res_o holds req_i.ready low only while a result is waiting.
// Head, tail, count and capacity reset to zero, zero, zero and DEPTH; the ring
// store is not cleared. The store read is registered and doubles as the
// message part of the result register.
// ----------------------------------------------------------------------------
module ring_message_queue_with_front_post_core #(
  parameter int unsigned DEPTH     = rmq_pkg::DepthDef,
  parameter int unsigned MSG_WIDTH = rmq_pkg::MsgWidthDef,
  localparam int unsigned AddrW = $clog2(DEPTH),
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rmq_req_if.sink                    req_i,
  rmq_res_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmq_pkg::PaddrW-1:0] paddr,
  input  logic [rmq_pkg::PdataW-1:0] pwdata,
  output logic [rmq_pkg::PdataW-1:0] prdata,
  output logic                       pready
);

  logic              fire;
  logic [CntW-1:0]   cap;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [MSG_WIDTH-1:0] ram_rdata;
  rmq_pkg::res_ctl_t ctl;
  logic [CntW-1:0]   count;

  logic              out_valid_q;
  rmq_pkg::status_e  status_q;
  logic              take_q;
  logic [CntW-1:0]   count_q;

  // request accepted whenever the result slot is free or being emptied
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  rmq_cfg #(
    .Depth (DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_o   (cap)
  );

  rmq_ctrl #(
    .Depth (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .action_i    (req_i.action),
    .cap_i       (cap),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ctl_o       (ctl),
    .count_o     (count)
  );

  rmq_ram #(
    .Width (MSG_WIDTH),
    .Depth (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.message_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= ctl.status;
      take_q   <= ctl.take;
      count_q  <= count;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = status_q;
  assign res_o.message_out = take_q ? ram_rdata : '0;
  assign res_o.entry_count = count_q;

endmodule

>>> sim/tb_ring_message_queue_with_front_post_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_message_queue_with_front_post_core : self-checking bench
// Drives post-back, post-front, receive and flush requests through the
// request channel, with bursts, gaps and result back-pressure. The capacity
// register is rewritten between phases. A behavioural model of the ring
// predicts every result, and a checker compares them in arrival order.
// ----------------------------------------------------------------------------
module tb_ring_message_queue_with_front_post_core;

  localparam int unsigned DEPTH = rmq_pkg::DepthDef;

  typedef struct packed {
    rmq_pkg::action_e action;
    logic [31:0]      message;
  } request_t;

  typedef struct packed {
    rmq_pkg::status_e status;
    logic [31:0]      message;
    logic [4:0]       count;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [rmq_pkg::PaddrW-1:0] paddr;
  logic [rmq_pkg::PdataW-1:0] pwdata;
  logic [rmq_pkg::PdataW-1:0] prdata;
  logic                       pready;

  rmq_req_if req_ch ();
  rmq_res_if res_ch ();

  ring_message_queue_with_front_post_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the ring and its pointers
  logic [31:0] ring_shadow [DEPTH];
  int unsigned tail_ptr = 0;
  int unsigned head_ptr = 0;
  int unsigned held     = 0;
  logic [4:0]  cap_reg  = 5'd16;

  request_t    request_backlog [$];
  result_t     pending_results [$];
  int unsigned issued_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned fail_count     = 0;

  // Driver and back-pressure state
  bit          req_fired  = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned step_ptr(int unsigned ptr, int unsigned cap);
    return (ptr + 1 >= cap) ? 0 : ptr + 1;
  endfunction

  // Result of one request, updating the shadow ring
  function automatic result_t predict_response(request_t rq);
    result_t     rs;
    int unsigned cap;
    cap        = (cap_reg == 5'd0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
    rs.status  = rmq_pkg::ST_OK;
    rs.message = '0;
    case (rq.action)
      rmq_pkg::ACT_POST_BACK, rmq_pkg::ACT_POST_FRONT: begin
        if (held >= cap) begin
          rs.status = rmq_pkg::ST_FULL;
        end else if (rq.action == rmq_pkg::ACT_POST_BACK) begin
          ring_shadow[tail_ptr] = rq.message;
          tail_ptr = step_ptr(tail_ptr, cap);
          held++;
        end else begin
          // head outside the new capacity drops to the last entry
          head_ptr = (head_ptr == 0 || head_ptr >= cap) ? cap - 1 : head_ptr - 1;
          ring_shadow[head_ptr] = rq.message;
          held++;
        end
      end
      rmq_pkg::ACT_RECEIVE: begin
        if (held == 0) begin
          rs.status = rmq_pkg::ST_EMPTY;
        end else begin
          rs.message = ring_shadow[head_ptr];
          head_ptr   = step_ptr(head_ptr, cap);
          held--;
        end
      end
      default: begin
        tail_ptr = 0;
        head_ptr = 0;
        held     = 0;
      end
    endcase
    rs.count = 5'(held);
    return rs;
  endfunction

  function automatic void flag_error(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  task automatic push_request(rmq_pkg::action_e act, logic [31:0] msg);
    request_backlog.push_back('{action: act, message: msg});
    issued_count++;
  endtask

  // Random requests; the post/receive balance drifts so the queue swings
  // between empty and full
  task automatic queue_random_requests(int unsigned n);
    int unsigned fill_pct;
    int unsigned pick;
    logic [31:0] word;
    fill_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 32 == 0) begin
        fill_pct = $urandom_range(20, 80);
      end
      case ($urandom_range(0, 7))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_request(rmq_pkg::ACT_FLUSH, word);
      end else if (pick < 3 + fill_pct) begin
        push_request(($urandom_range(0, 2) == 0) ? rmq_pkg::ACT_POST_FRONT
                                                 : rmq_pkg::ACT_POST_BACK, word);
      end else begin
        push_request(rmq_pkg::ACT_RECEIVE, word);
      end
    end
  endtask

  // Hold off until every request is in and every result checked
  task automatic wait_for_drain();
    while (accepted_count != issued_count || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Register write with setup and access phases, upper data bits random
  task automatic write_capacity(logic [4:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rmq_pkg::RegQueueCap, 2'b00};
    pwdata  <= {27'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Request driver: bursts of random length, random gaps in between
  always @(negedge clk_i) begin
    request_t next_req;
    if (rst_ni && (!req_ch.valid || req_fired)) begin
      if (gap_left != 0 || request_backlog.size() == 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end
        req_ch.valid <= 1'b0;
      end else begin
        next_req = request_backlog.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.action     <= next_req.action;
        req_ch.message_in <= next_req.message;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result back-pressure: long steady stretches, short stalls, choppy spells
  always @(negedge clk_i) begin
    int unsigned pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        res_ch.ready <= 1'b1;
        stall_left = $urandom_range(50, 200);
      end else if (pick < 5) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = $urandom_range(1, 12);
      end
    end else begin
      stall_left--;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    request_t seen;
    result_t  want;
    if (rst_ni) begin
      req_fired = req_ch.valid && req_ch.ready;
      if (req_fired) begin
        seen.action  = req_ch.action;
        seen.message = req_ch.message_in;
        pending_results.push_back(predict_response(seen));
        accepted_count++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          flag_error($sformatf("unexpected result status %0d msg %h count %0d",
                               res_ch.status, res_ch.message_out, res_ch.entry_count));
        end else begin
          want = pending_results.pop_front();
          if (res_ch.status !== want.status || res_ch.message_out !== want.message ||
              res_ch.entry_count !== want.count) begin
            flag_error($sformatf(
              "exp status %0d msg %h count %0d, got status %0d msg %h count %0d",
              want.status, want.message, want.count,
              res_ch.status, res_ch.message_out, res_ch.entry_count));
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    logic [4:0] cap_plan [13];
    cap_plan = '{5'd1, 5'd0, 5'd16, 5'd31, 5'd3, 5'd17, 5'd2, 5'd8,
                 5'd15, 5'd5, 5'd4, 5'd12, 5'd16};
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    req_ch.valid      = 1'b0;
    req_ch.action     = rmq_pkg::ACT_POST_BACK;
    req_ch.message_in = '0;
    res_ch.ready      = 1'b1;
    foreach (ring_shadow[i]) ring_shadow[i] = '0;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: front post on empty wraps the head, then fill every entry
    // so no receive can ever reach a slot that was never written
    push_request(rmq_pkg::ACT_POST_FRONT, 32'hFFFF_FFFF);
    push_request(rmq_pkg::ACT_POST_BACK, 32'h0000_0000);
    for (int i = 1; i < 15; i++) begin
      push_request(rmq_pkg::ACT_POST_BACK, {8'(i), 24'($urandom)});
    end
    // posts refused on a full queue
    push_request(rmq_pkg::ACT_POST_BACK, 32'h5A5A_5A5A);
    push_request(rmq_pkg::ACT_POST_FRONT, 32'hA5A5_A5A5);
    push_request(rmq_pkg::ACT_RECEIVE, 32'hFFFF_FFFF);
    push_request(rmq_pkg::ACT_RECEIVE, 32'h0);
    push_request(rmq_pkg::ACT_FLUSH, 32'h1234_5678);
    // receive on empty, flush on empty, priority message read straight back
    push_request(rmq_pkg::ACT_RECEIVE, 32'h0);
    push_request(rmq_pkg::ACT_FLUSH, 32'h0);
    push_request(rmq_pkg::ACT_POST_FRONT, 32'h0000_0000);
    push_request(rmq_pkg::ACT_POST_BACK, 32'h8000_0001);
    push_request(rmq_pkg::ACT_RECEIVE, 32'h0);
    push_request(rmq_pkg::ACT_RECEIVE, 32'h0);
    wait_for_drain();

    // Random phases, capacity rewritten with whatever is still held
    foreach (cap_plan[p]) begin
      write_capacity((p >= 11) ? 5'($urandom_range(0, 31)) : cap_plan[p]);
      queue_random_requests(148);
      wait_for_drain();
    end

    repeat (4) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rmq_pkg.sv
rtl/rmq_if.sv
rtl/rmq_ram.sv
rtl/rmq_cfg.sv
rtl/rmq_ctrl.sv
rtl/ring_message_queue_with_front_post_core.sv
sim/tb_ring_message_queue_with_front_post_core.sv
